// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

  // What the decoder hands to the emitter for one finished code point
  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] code_point;
    logic        eos;
  } entry_t;

  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
  localparam logic [20:0] SURR_FIRST = 21'h00D800;
  localparam logic [20:0] SURR_LAST  = 21'h00DFFF;
  localparam logic [20:0] PAIR_BASE  = 21'h010000;

  // Upper six bits of high and low surrogates (0xD800 and 0xDC00)
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  // Continuation byte marker in the top two bits
  localparam logic [1:0] CONT_TAG = 2'b10;

endpackage

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_stall    in_byte[7:0], in_end_of_string
// out_      output     out_valid/out_stall  out_code_unit[15:0], out_error,
//                                           out_run_last, out_string_done
//
// One byte is taken per cycle while in_stall is low; the decoder finishes a
// byte in the cycle it is accepted; its word goes through the queue and then
// the output register, which sends one word per cycle while out_stall is low.
// Reset (rst_n low, synchronous) clears the decoder state, the queue and the
// output register. in_stall rises only when the QUEUE_DEPTH-entry queue
// between decoder and emitter is full; out_stall holds the output word.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_error,
  output logic        out_run_last,
  output logic        out_string_done
);

  logic   push, q_full, pop, q_empty;
  entry_t push_entry, pop_entry;

  u8u16_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .push             (push),
    .push_entry       (push_entry)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  u8u16_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_entry         (pop_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_error       (out_error),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

endmodule

// ===== rtl/u8u16_front.sv =====
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [20:0] cp_r, cp_nxt, cp_work;
  logic [1:0]  rem_r, rem_nxt, rem_work;
  logic        skip_r, skip_nxt;
  logic        accept;
  logic        err;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Decode one byte, update the gathered code point, classify the result
  always_comb begin
    cp_nxt     = cp_r;
    rem_nxt    = rem_r;
    skip_nxt   = skip_r;
    cp_work    = cp_r;
    rem_work   = rem_r;
    err        = 1'b0;
    push       = 1'b0;
    push_entry = '{kind: KIND_UNIT, code_point: cp_r, eos: in_end_of_string};
    if (accept) begin
      if (skip_r) begin
        if (in_end_of_string) skip_nxt = 1'b0;
      end else begin
        if (rem_r == 2'd0) begin
          case (in_byte) inside
            [8'h00:8'h7F]: begin
              cp_work  = {13'd0, in_byte};
              rem_work = 2'd0;
            end
            [8'hC0:8'hDF]: begin
              cp_work  = {16'd0, in_byte[4:0]};
              rem_work = 2'd1;
            end
            [8'hE0:8'hEF]: begin
              cp_work  = {17'd0, in_byte[3:0]};
              rem_work = 2'd2;
            end
            [8'hF0:8'hF7]: begin
              cp_work  = {18'd0, in_byte[2:0]};
              rem_work = 2'd3;
            end
            default: err = 1'b1;
          endcase
        end else if (in_byte[7:6] != CONT_TAG) begin
          err = 1'b1;
        end else begin
          cp_work  = {cp_r[14:0], in_byte[5:0]};
          rem_work = rem_r - 2'd1;
        end

        if (!err) begin
          if (rem_work != 2'd0) begin
            // sequence still open; a string end here is truncation
            if (in_end_of_string) begin
              err = 1'b1;
            end else begin
              cp_nxt  = cp_work;
              rem_nxt = rem_work;
            end
          end else begin
            cp_nxt  = '0;
            rem_nxt = 2'd0;
            if ((cp_work >= SURR_FIRST && cp_work <= SURR_LAST) || cp_work > CP_MAX) begin
              err = 1'b1;
            end else begin
              push                  = 1'b1;
              push_entry.kind       = (cp_work > BMP_MAX) ? KIND_PAIR : KIND_UNIT;
              push_entry.code_point = cp_work;
            end
          end
        end

        if (err) begin
          cp_nxt                = '0;
          rem_nxt               = 2'd0;
          skip_nxt              = !in_end_of_string;
          push                  = 1'b1;
          push_entry.kind       = KIND_ERROR;
          push_entry.code_point = '0;
        end
      end
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r   <= '0;
      rem_r  <= 2'd0;
      skip_r <= 1'b0;
    end else begin
      cp_r   <= cp_nxt;
      rem_r  <= rem_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

// ===== rtl/u8u16_queue.sv =====
module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_entry;
  end

endmodule

// ===== rtl/u8u16_back.sv =====
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  entry_t      q_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_error,
  output logic        out_run_last,
  output logic        out_string_done
);

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic        error_r, error_nxt;
  logic        last_r, last_nxt;
  logic        done_r, done_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] pend_unit_r, pend_unit_nxt;
  logic        pend_done_r, pend_done_nxt;
  logic        out_free;
  logic [20:0] offset;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = out_free && !pend_r && !q_empty;
  assign offset   = q_entry.code_point - PAIR_BASE;

  // Output word select: pending low surrogate first, then the queue head
  always_comb begin
    out_valid_nxt = out_valid_r;
    unit_nxt      = unit_r;
    error_nxt     = error_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    pend_nxt      = pend_r;
    pend_unit_nxt = pend_unit_r;
    pend_done_nxt = pend_done_r;
    if (out_free) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        unit_nxt      = pend_unit_r;
        error_nxt     = 1'b0;
        last_nxt      = 1'b1;
        done_nxt      = pend_done_r;
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        case (q_entry.kind)
          KIND_UNIT: begin
            unit_nxt  = q_entry.code_point[15:0];
            error_nxt = 1'b0;
            last_nxt  = 1'b1;
            done_nxt  = q_entry.eos;
          end
          KIND_PAIR: begin
            unit_nxt      = {HI_SURR_TAG, offset[19:10]};
            error_nxt     = 1'b0;
            last_nxt      = 1'b0;
            done_nxt      = 1'b0;
            pend_nxt      = 1'b1;
            pend_unit_nxt = {LO_SURR_TAG, offset[9:0]};
            pend_done_nxt = q_entry.eos;
          end
          default: begin
            unit_nxt  = '0;
            error_nxt = 1'b1;
            last_nxt  = 1'b1;
            done_nxt  = 1'b1;
          end
        endcase
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    unit_r      <= unit_nxt;
    error_r     <= error_nxt;
    last_r      <= last_nxt;
    done_r      <= done_nxt;
    pend_unit_r <= pend_unit_nxt;
    pend_done_r <= pend_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_unit   = unit_r;
  assign out_error       = error_r;
  assign out_run_last    = last_r;
  assign out_string_done = done_r;

endmodule

// ===== rtl/u8u16_checker.sv =====
`include "assert_macros.svh"

module u8u16_checker
  import u8u16_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_byte,
  input logic        in_end_of_string,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_code_unit,
  input logic        out_error,
  input logic        out_run_last,
  input logic        out_string_done
);

  // A stalled output word holds
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_code_unit) && $stable(out_error) && $stable(out_run_last) && $stable(out_string_done), "output word changed while stalled")

  // An error word is zero and closes the run and the string
  `CHK_IMPLY(a_err_shape, clk, rst_n, out_valid && out_error, out_code_unit == 16'h0000 && out_run_last && out_string_done, "malformed error word")

  // The end of a string is also the end of its code point's run
  `CHK_IMPLY(a_done_last, clk, rst_n, out_valid && out_string_done, out_run_last, "string_done without run_last")

  // Only a high surrogate leaves a run open
  `CHK_IMPLY(a_hi_surr, clk, rst_n, out_valid && !out_run_last, !out_error && out_code_unit[15:10] == HI_SURR_TAG, "open run on a non high surrogate")

  // A taken high surrogate is followed at once by its low surrogate
  `CHK_NEXT(a_lo_follows, clk, rst_n, out_valid && !out_stall && !out_run_last, out_valid && !out_error && out_run_last && out_code_unit[15:10] == LO_SURR_TAG, "low surrogate missing")

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);
